FILE: rtl/g2cl_pkg.sv
// ----------------------------------------------------------------------------
// g2cl_pkg
// Shared types, constants and the lunar year table for the Gregorian to
// Chinese lunar date converter.
// ----------------------------------------------------------------------------
`default_nettype none

package g2cl_pkg;

  localparam int FIRST_YEAR_DEF  = 1901;
  localparam int TABLE_YEARS_DEF = 199;
  localparam int ROM_DEPTH       = 199;
  localparam int ROM_IDX_W       = 8;
  localparam int WORD_W          = 24;

  typedef struct packed {
    logic [11:0] solar_year;
    logic [3:0]  solar_month;
    logic [4:0]  solar_day;
  } solar_date_t;

  typedef struct packed {
    logic [11:0] lunar_year;
    logic [3:0]  lunar_month;
    logic [4:0]  lunar_day;
    logic        is_leap_month;
    logic        out_of_range;
  } lunar_date_t;

  // Word layout: [23:20] leap month, [19:7] month lengths of slots 1..13,
  // [6:5] festival month (1 is January), [4:0] festival day.
  localparam logic [WORD_W-1:0] YEAR_ROM [ROM_DEPTH] = '{
    24'h04AE53,24'h0A5748,24'h5526BD,24'h0D2650,24'h0D9544,24'h46AAB9,24'h056A4D,
    24'h09AD42,24'h24AEB6,24'h04AE4A,24'h6A4DBE,24'h0A4D52,24'h0D2546,24'h5D52BA,
    24'h0B544E,24'h0D6A43,24'h296D37,24'h095B4B,24'h749BC1,24'h049754,24'h0A4B48,
    24'h5B25BC,24'h06A550,24'h06D445,24'h4ADAB8,24'h02B64D,24'h095742,24'h2497B7,
    24'h04974A,24'h664B3E,24'h0D4A51,24'h0EA546,24'h56D4BA,24'h05AD4E,24'h02B644,
    24'h393738,24'h092E4B,24'h7C96BF,24'h0C9553,24'h0D4A48,24'h6DA53B,24'h0B554F,
    24'h056A45,24'h4AADB9,24'h025D4D,24'h092D42,24'h2C95B6,24'h0A954A,24'h7B4ABD,
    24'h06CA51,24'h0B5546,24'h555ABB,24'h04DA4E,24'h0A5B43,24'h352BB8,24'h052B4C,
    24'h8A953F,24'h0E9552,24'h06AA48,24'h6AD53C,24'h0AB54F,24'h04B645,24'h4A5739,
    24'h0A574D,24'h052642,24'h3E9335,24'h0D9549,24'h75AABE,24'h056A51,24'h096D46,
    24'h54AEBB,24'h04AD4F,24'h0A4D43,24'h4D26B7,24'h0D254B,24'h8D52BF,24'h0B5452,
    24'h0B6A47,24'h696D3C,24'h095B50,24'h049B45,24'h4A4BB9,24'h0A4B4D,24'hAB25C2,
    24'h06A554,24'h06D449,24'h6ADA3D,24'h0AB651,24'h093746,24'h5497BB,24'h04974F,
    24'h064B44,24'h36A537,24'h0EA54A,24'h86B2BF,24'h05AC53,24'h0AB647,24'h5936BC,
    24'h092E50,24'h0C9645,24'h4D4AB8,24'h0D4A4C,24'h0DA541,24'h25AAB6,24'h056A49,
    24'h7AADBD,24'h025D52,24'h092D47,24'h5C95BA,24'h0A954E,24'h0B4A43,24'h4B5537,
    24'h0AD54A,24'h955ABF,24'h04BA53,24'h0A5B48,24'h652BBC,24'h052B50,24'h0A9345,
    24'h474AB9,24'h06AA4C,24'h0AD541,24'h24DAB6,24'h04B64A,24'h69573D,24'h0A4E51,
    24'h0D2646,24'h5E933A,24'h0D534D,24'h05AA43,24'h36B537,24'h096D4B,24'hB4AEBF,
    24'h04AD53,24'h0A4D48,24'h6D25BC,24'h0D254F,24'h0D5244,24'h5DAA38,24'h0B5A4C,
    24'h056D41,24'h24ADB6,24'h049B4A,24'h7A4BBE,24'h0A4B51,24'h0AA546,24'h5B52BA,
    24'h06D24E,24'h0ADA42,24'h355B37,24'h09374B,24'h8497C1,24'h049753,24'h064B48,
    24'h66A53C,24'h0EA54F,24'h06B244,24'h4AB638,24'h0AAE4C,24'h092E42,24'h3C9735,
    24'h0C9649,24'h7D4ABD,24'h0D4A51,24'h0DA545,24'h55AABA,24'h056A4E,24'h0A6D43,
    24'h452EB7,24'h052D4B,24'h8A95BF,24'h0A9553,24'h0B4A47,24'h6B553B,24'h0AD54F,
    24'h055A45,24'h4A5D38,24'h0A5B4C,24'h052B42,24'h3A93B6,24'h069349,24'h7729BD,
    24'h06AA51,24'h0AD546,24'h54DABA,24'h04B64E,24'h0A5743,24'h452738,24'h0D264A,
    24'h8E933E,24'h0D5252,24'h0DAA47,24'h66B53B,24'h056D4F,24'h04AE45,24'h4A4EB9,
    24'h0A4D4C,24'h0D1541,24'h2D92B5
  };

  // Days before the first of each Gregorian month in a common year.
  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };

endpackage

`default_nettype wire

FILE: rtl/g2cl_if.sv
// ----------------------------------------------------------------------------
// g2cl_if
// Valid/ready channels for the solar date input and the lunar date result.
// ----------------------------------------------------------------------------
`default_nettype none

interface g2cl_solar_if;
  logic                   valid;
  logic                   ready;
  g2cl_pkg::solar_date_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface g2cl_lunar_if;
  logic                   valid;
  logic                   ready;
  g2cl_pkg::lunar_date_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/g2cl_year_rom.sv
// ----------------------------------------------------------------------------
// g2cl_year_rom
// Synchronous year table: one lunar year word per Gregorian year, data
// registered in the cycle after the read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module g2cl_year_rom #(
  parameter int TABLE_YEARS = g2cl_pkg::TABLE_YEARS_DEF,
  parameter int IDX_W       = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rd_en,
  input  wire logic [IDX_W-1:0]            rd_addr,
  output      logic [g2cl_pkg::WORD_W-1:0] rd_data
);
  import g2cl_pkg::*;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= YEAR_ROM[ROM_IDX_W'(rd_addr)];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gregorian_to_chinese_lunar_date.sv
// ----------------------------------------------------------------------------
// gregorian_to_chinese_lunar_date
// Converts a Gregorian date in 1901..2099 to the Chinese lunar date by
// walking lunar months from the spring festival of the year table.
// ----------------------------------------------------------------------------
//
//   channel  dir  payload        transfer when
//   solar    in   solar_date_t   solar.valid && solar.ready
//   lunar    out  lunar_date_t   lunar.valid && lunar.ready
//
// One date passes through these steps: accept, table word setup, a walk of
// at most 13 lunar months, one extra table read when the date lies before
// the festival, and a hand-over to the output register. A year outside the
// table skips the setup and the walk.
// solar.ready is high only while no date is in work; a finished result may
// wait in the output register while the next date is taken.
// Reset is synchronous and clears the sequencer and the output valid flag.
`default_nettype none

module gregorian_to_chinese_lunar_date #(
  parameter int FIRST_YEAR  = g2cl_pkg::FIRST_YEAR_DEF,
  parameter int TABLE_YEARS = g2cl_pkg::TABLE_YEARS_DEF
) (
  input wire logic       clk,
  input wire logic       rst,
  g2cl_solar_if.sink     solar,
  g2cl_lunar_if.source   lunar
);
  import g2cl_pkg::*;

  localparam int IDX_W = (TABLE_YEARS > 1) ? $clog2(TABLE_YEARS) : 1;
  localparam logic [11:0] FIRST_Y = 12'(FIRST_YEAR);
  localparam logic [11:0] YEARS_N = 12'(TABLE_YEARS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_RD1   = 3'd2;
  localparam logic [2:0] S_FWD   = 3'd3;
  localparam logic [2:0] S_BWD   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state;
  logic [IDX_W-1:0]  idx;
  logic [11:0]       year_q;
  logic [8:0]        doy;
  logic [3:0]        slot;
  logic [8:0]        off;
  lunar_date_t       res;
  lunar_date_t       out_data;
  logic              out_valid;

  logic              rom_en;
  logic [IDX_W-1:0]  rom_addr;
  logic [WORD_W-1:0] word;

  // Input side decode.
  logic              in_xfer;
  logic [11:0]       diff;
  logic              in_range;
  logic [3:0]        mon_c;
  logic [4:0]        day_c;
  logic [8:0]        doy_in;

  // Walk helpers on the current table word.
  logic [5:0]        spring;
  logic [4:0]        len;
  logic [3:0]        nslots;
  logic              before_fest;
  logic              out_free;

  // Returns the month number in the upper four bits and the leap mark below.
  function automatic logic [4:0] label(input logic [3:0] lm, input logic [3:0] s);
    logic [3:0] mon;
    logic       leap;
    leap = 1'b0;
    if (lm == 4'd0 || s <= lm) begin
      mon = s;
    end else if ({1'b0, s} == {1'b0, lm} + 5'd1) begin
      mon  = lm;
      leap = 1'b1;
    end else begin
      mon = s - 4'd1;
    end
    return {mon, leap};
  endfunction

  assign in_xfer  = solar.valid && solar.ready;
  assign diff     = solar.data.solar_year - FIRST_Y;
  assign in_range = (solar.data.solar_year >= FIRST_Y) && (diff < YEARS_N);

  always_comb begin
    mon_c = solar.data.solar_month;
    if (mon_c == 4'd0) mon_c = 4'd1;
    if (mon_c > 4'd12) mon_c = 4'd12;
    day_c = (solar.data.solar_day == 5'd0) ? 5'd1 : solar.data.solar_day;
    doy_in = DAYS_BEFORE[mon_c - 4'd1] + 9'(day_c) - 9'd1;
    if (solar.data.solar_year[1:0] == 2'd0 && mon_c > 4'd2) doy_in = doy_in + 9'd1;
  end

  assign spring = {1'b0, word[4:0]} + ((word[6:5] != 2'd1) ? 6'd31 : 6'd0) - 6'd1;
  assign before_fest = doy < {3'd0, spring};
  assign len    = word[5'd20 - {1'b0, slot}] ? 5'd30 : 5'd29;
  assign nslots = (word[23:20] != 4'd0) ? 4'd13 : 4'd12;
  assign out_free = !out_valid || lunar.ready;

  assign rom_en   = (in_xfer && in_range) ||
                    (state == S_SETUP && before_fest && idx != '0);
  assign rom_addr = (state == S_IDLE) ? diff[IDX_W-1:0] : idx - IDX_W'(1);

  g2cl_year_rom #(
    .TABLE_YEARS (TABLE_YEARS),
    .IDX_W       (IDX_W)
  ) u_rom (
    .clk     (clk),
    .rd_en   (rom_en),
    .rd_addr (rom_addr),
    .rd_data (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            idx    <= diff[IDX_W-1:0];
            year_q <= solar.data.solar_year;
            doy    <= doy_in;
            if (in_range) begin
              state <= S_SETUP;
            end else begin
              res   <= '{lunar_year: 12'd0, lunar_month: 4'd0, lunar_day: 5'd0,
                         is_leap_month: 1'b0, out_of_range: 1'b1};
              state <= S_DONE;
            end
          end
        end
        S_SETUP: begin
          if (!before_fest) begin
            off   <= doy - {3'd0, spring};
            slot  <= 4'd1;
            state <= S_FWD;
          end else if (idx == '0) begin
            // The previous lunar year is not in the table.
            res   <= '{lunar_year: year_q - 12'd1, lunar_month: 4'd0, lunar_day: 5'd0,
                       is_leap_month: 1'b0, out_of_range: 1'b1};
            state <= S_DONE;
          end else begin
            off   <= {3'd0, spring} - doy;
            state <= S_RD1;
          end
        end
        S_RD1: begin
          slot  <= nslots;
          state <= S_BWD;
        end
        S_FWD: begin
          if (off >= 9'(len) && slot < nslots) begin
            off  <= off - 9'(len);
            slot <= slot + 4'd1;
          end else begin
            res.lunar_year   <= year_q;
            res.lunar_day    <= (off >= 9'd31) ? 5'd31 : off[4:0] + 5'd1;
            res.out_of_range <= 1'b0;
            {res.lunar_month, res.is_leap_month} <= label(word[23:20], slot);
            state <= S_DONE;
          end
        end
        S_BWD: begin
          // Here off counts the days still to go back to the festival.
          if (off > 9'(len) && slot > 4'd1) begin
            off  <= off - 9'(len);
            slot <= slot - 4'd1;
          end else begin
            res.lunar_year   <= year_q - 12'd1;
            res.lunar_day    <= (off > 9'(len)) ? 5'd1 : len + 5'd1 - off[4:0];
            res.out_of_range <= 1'b0;
            {res.lunar_month, res.is_leap_month} <= label(word[23:20], slot);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (lunar.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data <= res;
    end
  end

  assign solar.ready = (state == S_IDLE);
  assign lunar.valid = out_valid;
  assign lunar.data  = out_data;

endmodule

`default_nettype wire

FILE: rtl/g2cl_checker.sv
// ----------------------------------------------------------------------------
// g2cl_checker
// Port-level checks on the lunar date converter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module g2cl_checker (
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire g2cl_pkg::lunar_date_t out_data
);
  import g2cl_pkg::*;

  logic       in_xfer;
  logic       out_xfer;
  logic [1:0] pending;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // Dates taken whose result has not yet been transferred out.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      pending <= pending + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      pending <= pending - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  a_no_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0 && pending != 2'd3)
    else $error("result without a matching input date");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !in_ready)
    else $error("second date taken while one is in work");

  a_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.out_of_range |->
      out_data.lunar_month >= 4'd1 && out_data.lunar_month <= 4'd12 &&
      out_data.lunar_day >= 5'd1 && out_data.lunar_day <= 5'd31)
    else $error("lunar date fields outside their range");

endmodule

bind gregorian_to_chinese_lunar_date g2cl_checker u_g2cl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (solar.valid),
  .in_ready  (solar.ready),
  .out_valid (lunar.valid),
  .out_ready (lunar.ready),
  .out_data  (lunar.data)
);

`default_nettype wire

FILE: tb/sv/lunar_date_checker.sv
// ----------------------------------------------------------------------------
// lunar_date_checker
// Watches the solar date and lunar date channels, works out the lunar date
// that each accepted solar date should give, and compares every result with
// the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------

module lunar_date_checker (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  solar_valid,
  input  logic                  solar_ready,
  input  g2cl_pkg::solar_date_t solar_data,
  input  logic                  lunar_valid,
  input  logic                  lunar_ready,
  input  g2cl_pkg::lunar_date_t lunar_data,
  output int                    mismatches,
  output int                    pending,
  output int                    checked,
  output int                    leap_hits
);

  localparam int BASE_YEAR  = 1901;
  localparam int YEAR_COUNT = 199;

  // One word per Gregorian year: leap month, month lengths, festival date.
  localparam logic [23:0] LUNAR_YEARS [YEAR_COUNT] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
    24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
    24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
    24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
    24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
    24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
    24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
    24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
    24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
    24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
    24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
    24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
    24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
    24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
    24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
    24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
    24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
    24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
    24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
    24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
    24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
    24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
    24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  localparam int CUM_DAYS [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

  g2cl_pkg::lunar_date_t expected_dates [$];
  g2cl_pkg::lunar_date_t want;

  initial begin
    mismatches = 0;
    pending    = 0;
    checked    = 0;
    leap_hits  = 0;
  end

  // Month slots run from 1 to 13 and sit at bits 19 down to 7.
  function automatic int moon_days(logic [23:0] word, int slot);
    return word[20 - slot] ? 30 : 29;
  endfunction

  function automatic int moon_count(logic [23:0] word);
    return (word[23:20] != 4'd0) ? 13 : 12;
  endfunction

  function automatic g2cl_pkg::lunar_date_t convert_to_lunar(g2cl_pkg::solar_date_t s);
    g2cl_pkg::lunar_date_t r;
    logic [23:0] word;
    logic [23:0] prev;
    int yr, idx, mon, dom, festival, doy, off, slot, rem, d, leap_mon;
    r   = '0;
    yr  = int'(s.solar_year);
    if (yr < BASE_YEAR || yr - BASE_YEAR >= YEAR_COUNT) begin
      r.out_of_range = 1'b1;
      return r;
    end
    idx  = yr - BASE_YEAR;
    word = LUNAR_YEARS[idx];
    mon  = int'(s.solar_month);
    dom  = int'(s.solar_day);
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    if (dom < 1) dom = 1;

    festival = int'(word[4:0]) - 1;
    if (word[6:5] != 2'd1) festival += 31;
    doy = CUM_DAYS[mon - 1] + dom - 1;
    if (yr % 4 == 0 && mon > 2) doy++;

    if (doy >= festival) begin
      off  = doy - festival;
      slot = 1;
      while (off >= moon_days(word, slot) && slot < moon_count(word)) begin
        off -= moon_days(word, slot);
        slot++;
      end
      d    = off + 1;
      prev = word;
      r.lunar_year = 12'(yr);
    end else begin
      // Before the festival the date belongs to the previous lunar year.
      if (idx == 0) begin
        r.lunar_year   = 12'(yr - 1);
        r.out_of_range = 1'b1;
        return r;
      end
      prev = LUNAR_YEARS[idx - 1];
      slot = moon_count(prev);
      rem  = festival - doy;
      while (rem > moon_days(prev, slot) && slot > 1) begin
        rem -= moon_days(prev, slot);
        slot--;
      end
      d = moon_days(prev, slot) - rem + 1;
      r.lunar_year = 12'(yr - 1);
    end
    if (d < 1) d = 1;
    if (d > 31) d = 31;

    leap_mon = int'(prev[23:20]);
    if (leap_mon == 0 || slot <= leap_mon) begin
      r.lunar_month = 4'(slot);
    end else if (slot == leap_mon + 1) begin
      r.lunar_month   = 4'(leap_mon);
      r.is_leap_month = 1'b1;
    end else begin
      r.lunar_month = 4'(slot - 1);
    end
    r.lunar_day = 5'(d);
    return r;
  endfunction

  function automatic void compare_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: lunar %s mismatch: expected %0d, got %0d", $time, name, exp_val, act_val);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (solar_valid && solar_ready) begin
        expected_dates.push_back(convert_to_lunar(solar_data));
      end
      if (lunar_valid && lunar_ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: lunar result with none outstanding: expected nothing, got %h",
                   $time, lunar_data);
          mismatches++;
        end else begin
          want = expected_dates.pop_front();
          compare_field("year", want.lunar_year, lunar_data.lunar_year);
          compare_field("month", want.lunar_month, lunar_data.lunar_month);
          compare_field("day", want.lunar_day, lunar_data.lunar_day);
          compare_field("leap flag", want.is_leap_month, lunar_data.is_leap_month);
          compare_field("range flag", want.out_of_range, lunar_data.out_of_range);
          checked++;
          if (want.is_leap_month) leap_hits++;
        end
      end
      pending = expected_dates.size();
    end
  end

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives Gregorian dates into the lunar date converter: a directed set of
// edge cases, then random dates under several patterns of input gaps and
// output back-pressure. The checker beside the block judges each result.
// ----------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int BURST_ITEMS = 220;
  localparam int FILL_ITEMS  = 80;
  localparam int SETTLE      = 40;

  typedef enum {
    PH_DIRECTED, PH_NO_IDLE, PH_SRC_IDLE, PH_SINK_STALL, PH_BOTH_IDLE, PH_FILL
  } phase_e;

  logic   clk = 1'b0;
  logic   rst;
  phase_e phase;
  int     src_idle_pct;
  int     sink_stall_pct;
  int     cycle_count = 0;
  int     dates_sent  = 0;
  bit     hold_done   = 1'b0;
  int     mismatches, pending, checked, leap_hits;

  g2cl_solar_if solar_if ();
  g2cl_lunar_if lunar_if ();

  gregorian_to_chinese_lunar_date dut (
    .clk   (clk),
    .rst   (rst),
    .solar (solar_if),
    .lunar (lunar_if)
  );

  lunar_date_checker date_check (
    .clk         (clk),
    .rst         (rst),
    .solar_valid (solar_if.valid),
    .solar_ready (solar_if.ready),
    .solar_data  (solar_if.data),
    .lunar_valid (lunar_if.valid),
    .lunar_ready (lunar_if.ready),
    .lunar_data  (lunar_if.data),
    .mismatches  (mismatches),
    .pending     (pending),
    .checked     (checked),
    .leap_hits   (leap_hits)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("testbench: errors");
      $finish;
    end
  end

  // Result side: random stalls, and once a long hold-off so the block fills up.
  initial begin
    lunar_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      if (phase == PH_FILL && !hold_done) begin
        hold_done = 1'b1;
        lunar_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        lunar_if.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
        @(negedge clk);
      end
    end
  end

  function automatic g2cl_pkg::solar_date_t make_date(int yr, int mon, int dom);
    g2cl_pkg::solar_date_t s;
    s.solar_year  = 12'(yr);
    s.solar_month = 4'(mon);
    s.solar_day   = 5'(dom);
    return s;
  endfunction

  function automatic g2cl_pkg::solar_date_t random_date();
    int pick, yr, mon, last_day;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      return make_date($urandom_range(0, 4095), $urandom_range(0, 15), $urandom_range(0, 31));
    end
    if (pick < 16) yr = $urandom_range(0, 1) ? 1901 : 2099;
    else yr = $urandom_range(1901, 2099);
    // Many dates fall in January and February, around the spring festival.
    mon = (pick < 45) ? $urandom_range(1, 2) : $urandom_range(1, 12);
    if (mon == 2) last_day = (yr % 4 == 0) ? 29 : 28;
    else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) last_day = 30;
    else last_day = 31;
    if (pick >= 92) last_day = 31;
    return make_date(yr, mon, $urandom_range(1, last_day));
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_date(g2cl_pkg::solar_date_t s);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      solar_if.valid <= 1'b0;
      @(negedge clk);
    end
    solar_if.valid <= 1'b1;
    solar_if.data  <= s;
    do @(posedge clk); while (!solar_if.ready);
    dates_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    solar_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic run_burst(phase_e ph, int count, int src_pct, int sink_pct);
    phase          = ph;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    repeat (count) send_date(random_date());
    drain_results();
  endtask

  initial begin
    rst            = 1'b1;
    solar_if.valid = 1'b0;
    solar_if.data  = '0;
    phase          = PH_DIRECTED;
    src_idle_pct   = 21;
    sink_stall_pct = 21;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_date(make_date(0, 1, 1));          // far below the table
    send_date(make_date(4095, 15, 31));     // every input bit set
    send_date(make_date(1900, 12, 31));
    send_date(make_date(2100, 1, 1));
    send_date(make_date(1901, 1, 1));       // first table year, before its festival
    send_date(make_date(1901, 2, 18));
    send_date(make_date(1901, 2, 19));      // first festival of the table
    send_date(make_date(1901, 12, 31));
    send_date(make_date(1902, 1, 1));
    send_date(make_date(2000, 0, 0));       // month and day of zero
    send_date(make_date(2000, 15, 31));     // month above December
    send_date(make_date(2000, 2, 29));
    send_date(make_date(2001, 2, 31));      // runs on into March
    send_date(make_date(2023, 3, 22));      // intercalary second month
    send_date(make_date(2023, 4, 20));
    send_date(make_date(2033, 12, 22));     // intercalary eleventh month
    send_date(make_date(2034, 1, 31));
    send_date(make_date(2099, 1, 1));
    send_date(make_date(2099, 12, 31));
    send_date(make_date(1984, 2, 2));
    send_date(make_date(2050, 6, 15));
    drain_results();

    run_burst(PH_NO_IDLE, BURST_ITEMS, 0, 0);
    run_burst(PH_SRC_IDLE, BURST_ITEMS, 69, 0);
    run_burst(PH_SINK_STALL, BURST_ITEMS, 0, 69);
    run_burst(PH_BOTH_IDLE, BURST_ITEMS, 21, 21);
    run_burst(PH_FILL, FILL_ITEMS, 0, 0);

    repeat (SETTLE) @(posedge clk);
    $display("Run summary: %0d dates sent and %0d lunar results checked, %0d in a leap month.",
             dates_sent, checked, leap_hits);
    $display("Covered years outside the table, clamped fields, both walk directions %s",
             "and a long output hold-off.");
    if (mismatches == 0 && pending == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/g2cl_pkg.sv
rtl/g2cl_if.sv
rtl/g2cl_year_rom.sv
rtl/gregorian_to_chinese_lunar_date.sv
rtl/g2cl_checker.sv
tb/sv/lunar_date_checker.sv
tb/sv/testbench.sv
